[hdl/key_controlled_stepper_half_step_macros.svh]
// Assertion macros shared by the stepper sequencer modules.
// Needs no other file; included by the modules that carry assertions.
`ifndef KEY_CONTROLLED_STEPPER_HALF_STEP_MACROS_SVH
`define KEY_CONTROLLED_STEPPER_HALF_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kcs_pkg.sv]
// Types, constants and the half-step phase table of the stepper sequencer.
// Has no dependencies; used by every module of the block.
package kcs_pkg;

  typedef enum logic {
    REG_FASTEST = 1'b0,
    REG_SLOWEST = 1'b1
  } reg_idx_t;

  localparam logic [3:0] FASTEST_RESET = 4'd1;
  localparam logic [3:0] SLOWEST_RESET = 4'd5;
  localparam logic [3:0] PERIOD_RESET  = 4'd1;
  localparam logic [3:0] PERIOD_FLOOR  = 4'd1;
  localparam logic [2:0] INDEX_LAST    = 3'd7;

  typedef struct packed {
    logic [3:0] fastest_period;
    logic [3:0] slowest_period;
  } cfg_t;

  typedef struct packed {
    logic toggle;
    logic faster;
    logic slower;
    logic spare;
  } keys_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       stepped;
    logic       direction_now;
    logic [3:0] period_now;
  } result_t;

  function automatic logic [3:0] phase_of(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

[hdl/key_controlled_stepper_half_step.sv]
// Half-step stepper sequencer with key control. Each input transfer is one
// millisecond tick with four active-low keys and yields exactly one result
// transfer, registered in the cycle after the input transfer. The block takes
// one tick per clock: the only storage between the sides is the single
// result register, which is refilled in the same cycle it is emptied, so
// in_ready is low only while a result waits and out_ready is low.
// Depends on kcs_pkg, kcs_regs, kcs_core and the assertion macro header.
`include "key_controlled_stepper_half_step_macros.svh"

module key_controlled_stepper_half_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_key_toggle_n,
  input  logic        in_key_faster_n,
  input  logic        in_key_slower_n,
  input  logic        in_key_spare_n,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_coils,
  output logic        out_stepped,
  output logic        out_direction_now,
  output logic [3:0]  out_period_now
);

  kcs_pkg::cfg_t    cfg;
  kcs_pkg::keys_t   keys;
  kcs_pkg::result_t res;
  kcs_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_fire;
  logic             out_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign keys.toggle = !in_key_toggle_n;
  assign keys.faster = !in_key_faster_n;
  assign keys.slower = !in_key_slower_n;
  assign keys.spare  = !in_key_spare_n;

  kcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  kcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .keys  (keys),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coils         = res_r.coils;
  assign out_stepped       = res_r.stepped;
  assign out_direction_now = res_r.direction_now;
  assign out_period_now    = res_r.period_now;

  `KCS_ASSERT_NEXT(a_drain_empties, clk, rst_n, out_fire && !in_fire, !out_valid_r, "Result register not emptied after transfer.")
  `KCS_ASSERT_NEXT(a_fill_sets_valid, clk, rst_n, in_fire, out_valid_r, "Accepted tick produced no result.")

endmodule

[hdl/kcs_regs.sv]
// APB-style configuration registers holding the fastest and slowest periods.
// Depends on kcs_pkg.
module kcs_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output kcs_pkg::cfg_t     cfg
);

  logic                  wr_en;
  kcs_pkg::reg_idx_t     sel;
  logic [3:0]            fastest_r;
  logic [3:0]            slowest_r;

  assign sel    = kcs_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fastest_r <= kcs_pkg::FASTEST_RESET;
      slowest_r <= kcs_pkg::SLOWEST_RESET;
    end else if (wr_en) begin
      case (sel)
        kcs_pkg::REG_FASTEST: fastest_r <= pwdata[3:0];
        kcs_pkg::REG_SLOWEST: slowest_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      kcs_pkg::REG_FASTEST: prdata = {28'd0, fastest_r};
      kcs_pkg::REG_SLOWEST: prdata = {28'd0, slowest_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.fastest_period = fastest_r;
  assign cfg.slowest_period = slowest_r;

endmodule

[hdl/kcs_core.sv]
// Sequencer state and the per-tick step logic: key scan, period, phase, wait.
// Depends on kcs_pkg and the shared assertion macro header.
`include "key_controlled_stepper_half_step_macros.svh"

module kcs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  kcs_pkg::keys_t    keys,
  input  kcs_pkg::cfg_t     cfg,
  output kcs_pkg::result_t  res
);

  logic [2:0] step_index_r, step_index_nxt;
  logic       direction_r, direction_nxt;
  logic [3:0] period_r, period_nxt;
  logic [3:0] wait_r, wait_nxt;
  logic       armed_r, armed_nxt;
  logic [3:0] coil_r, coil_nxt;
  logic       any_key;
  logic       do_step;
  logic [2:0] phase_idx;

  assign any_key = keys.toggle || keys.faster || keys.slower || keys.spare;
  assign do_step = (wait_r == 4'd0);

  always_comb begin
    step_index_nxt = step_index_r;
    direction_nxt  = direction_r;
    period_nxt     = period_r;
    armed_nxt      = armed_r;
    coil_nxt       = coil_r;
    wait_nxt       = wait_r - 4'd1;
    phase_idx      = 3'd0;
    if (do_step) begin
      if (armed_r && any_key) begin
        armed_nxt = 1'b0;
        if (keys.toggle) begin
          direction_nxt = !direction_r;
        end else if (keys.faster) begin
          if ((period_r > cfg.fastest_period) && (period_r > kcs_pkg::PERIOD_FLOOR)) begin
            period_nxt = period_r - 4'd1;
          end
        end else if (keys.slower) begin
          if (period_r < cfg.slowest_period) begin
            period_nxt = period_r + 4'd1;
          end
        end
      end else if (!any_key) begin
        armed_nxt = 1'b1;
      end
      phase_idx      = direction_nxt ? step_index_r : (kcs_pkg::INDEX_LAST - step_index_r);
      coil_nxt       = kcs_pkg::phase_of(phase_idx);
      step_index_nxt = step_index_r + 3'd1;
      wait_nxt       = period_nxt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_index_r <= 3'd0;
      direction_r  <= 1'b0;
      period_r     <= kcs_pkg::PERIOD_RESET;
      wait_r       <= 4'd0;
      armed_r      <= 1'b1;
      coil_r       <= 4'd0;
    end else if (fire) begin
      step_index_r <= step_index_nxt;
      direction_r  <= direction_nxt;
      period_r     <= period_nxt;
      wait_r       <= wait_nxt;
      armed_r      <= armed_nxt;
      coil_r       <= coil_nxt;
    end
  end

  assign res.coils         = coil_nxt;
  assign res.stepped       = do_step;
  assign res.direction_now = direction_nxt;
  assign res.period_now    = period_nxt;

  `KCS_ASSERT_SAME(a_period_nonzero, clk, rst_n, 1'b1, period_r != 4'd0, "Step period is zero.")
  `KCS_ASSERT_NEXT(a_idle_tick_holds, clk, rst_n, fire && !do_step, $stable(coil_r) && $stable(step_index_r) && $stable(period_r), "Idle tick changed step state.")
  `KCS_ASSERT_NEXT(a_wait_reload, clk, rst_n, fire && do_step, wait_r == (period_r - 4'd1), "Wait count not reloaded from period.")

endmodule

[dv/key_controlled_stepper_half_step_test.sv]
// Self-checking testbench for the key-controlled half-step stepper sequencer.
// Predicts every result transfer from its own model of the stepper and checks it
// field by field. Depends on kcs_pkg and the key_controlled_stepper_half_step RTL.
module key_controlled_stepper_half_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam logic [31:0] HALF_STEP_SEQ   = 32'h98C4_6231;

  localparam kcs_pkg::keys_t KEYS_IDLE    = 4'b1111;
  localparam kcs_pkg::keys_t PRESS_TOGGLE = 4'b0111;
  localparam kcs_pkg::keys_t PRESS_FASTER = 4'b1011;
  localparam kcs_pkg::keys_t PRESS_SLOWER = 4'b1101;
  localparam kcs_pkg::keys_t PRESS_SPARE  = 4'b1110;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_key_toggle_n = 1'b1;
  logic        in_key_faster_n = 1'b1;
  logic        in_key_slower_n = 1'b1;
  logic        in_key_spare_n = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_coils;
  logic        out_stepped;
  logic        out_direction_now;
  logic [3:0]  out_period_now;

  logic [3:0] fastest_cfg = kcs_pkg::FASTEST_RESET;
  logic [3:0] slowest_cfg = kcs_pkg::SLOWEST_RESET;
  logic [2:0] phase_idx;
  logic       dir_cw;
  logic [3:0] period;
  logic [3:0] wait_left;
  logic       armed;
  logic [3:0] coils_held;

  kcs_pkg::keys_t   key_ticks[$];
  kcs_pkg::result_t expected_status[$];
  int unsigned errors = 0;
  int unsigned rx_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned quiet_cycles = 0;

  key_controlled_stepper_half_step i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_toggle_n  (in_key_toggle_n),
    .in_key_faster_n  (in_key_faster_n),
    .in_key_slower_n  (in_key_slower_n),
    .in_key_spare_n   (in_key_spare_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coils        (out_coils),
    .out_stepped      (out_stepped),
    .out_direction_now(out_direction_now),
    .out_period_now   (out_period_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One millisecond tick: either count down the wait or take a step.
  function automatic kcs_pkg::result_t advance_stepper(input kcs_pkg::keys_t lv);
    logic             any_pressed;
    logic [2:0]       idx;
    kcs_pkg::result_t r;
    any_pressed = ~&lv;
    r.stepped = 1'b0;
    if (wait_left != 4'd0) begin
      wait_left = wait_left - 4'd1;
    end else begin
      r.stepped = 1'b1;
      if (armed && any_pressed) begin
        armed = 1'b0;
        if (!lv.toggle) begin
          dir_cw = ~dir_cw;
        end else if (!lv.faster) begin
          if (period > fastest_cfg && period > kcs_pkg::PERIOD_FLOOR) period = period - 4'd1;
        end else if (!lv.slower) begin
          if (period < slowest_cfg) period = period + 4'd1;
        end
      end else if (!any_pressed) begin
        armed = 1'b1;
      end
      idx = dir_cw ? phase_idx : kcs_pkg::INDEX_LAST - phase_idx;
      coils_held = HALF_STEP_SEQ[idx * 4 +: 4];
      phase_idx = phase_idx + 3'd1;
      wait_left = period - 4'd1;
    end
    r.coils = coils_held;
    r.direction_now = dir_cw;
    r.period_now = period;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic push_ticks(input kcs_pkg::keys_t lv, input int unsigned count);
    repeat (count) key_ticks.push_back(lv);
  endtask

  // Mostly press-and-release sequences so that the one-shot scan rearms,
  // with some bursts of arbitrary key levels mixed in.
  task automatic queue_key_ticks(input int unsigned count);
    kcs_pkg::keys_t lv;
    int unsigned    hold;
    int unsigned    queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 7))
          0:       lv = PRESS_TOGGLE;
          1, 2:    lv = PRESS_FASTER;
          3, 4:    lv = PRESS_SLOWER;
          5:       lv = PRESS_SPARE;
          default: lv = kcs_pkg::keys_t'(4'($urandom_range(0, 14)));
        endcase
        hold = $urandom_range(1, 16);
        push_ticks(lv, hold);
        queued += hold;
        hold = $urandom_range(1, 16);
        push_ticks(KEYS_IDLE, hold);
        queued += hold;
      end else begin
        hold = $urandom_range(1, 8);
        repeat (hold) key_ticks.push_back(kcs_pkg::keys_t'(4'($urandom_range(0, 15))));
        queued += hold;
      end
    end
  endtask

  task automatic write_reg(input kcs_pkg::reg_idx_t idx, input logic [3:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {28'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == kcs_pkg::REG_FASTEST) fastest_cfg = value;
    else slowest_cfg = value;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (key_ticks.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] fastest, input logic [3:0] slowest,
                           input int unsigned count);
    write_reg(kcs_pkg::REG_FASTEST, fastest);
    write_reg(kcs_pkg::REG_SLOWEST, slowest);
    queue_key_ticks(count);
    settle();
  endtask

  always @(posedge clk) begin : drive_ticks
    kcs_pkg::keys_t lv;
    logic           valid_next;
    valid_next = in_valid;
    if (!rst_n) begin
      phase_idx = 3'd0;
      dir_cw = 1'b0;
      period = kcs_pkg::PERIOD_RESET;
      wait_left = 4'd0;
      armed = 1'b1;
      coils_held = 4'd0;
      valid_next = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lv = {in_key_toggle_n, in_key_faster_n, in_key_slower_n, in_key_spare_n};
        expected_status.push_back(advance_stepper(lv));
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (key_ticks.size() != 0) begin
          lv = key_ticks.pop_front();
          in_key_toggle_n <= lv.toggle;
          in_key_faster_n <= lv.faster;
          in_key_slower_n <= lv.slower;
          in_key_spare_n <= lv.spare;
          valid_next = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= valid_next;
  end

  always @(posedge clk) begin : pace_results
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && rx_count >= HOLD_OFF_AT) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 2) == 0);
          default: out_ready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    kcs_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_count++;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got coils %h stepped %b %s",
                 $time, out_coils, out_stepped,
                 $sformatf("dir %b period %0d", out_direction_now, out_period_now));
      end else begin
        want = expected_status.pop_front();
        check_field("coils", want.coils, out_coils);
        check_field("stepped", {3'd0, want.stepped}, {3'd0, out_stepped});
        check_field("direction_now", {3'd0, want.direction_now}, {3'd0, out_direction_now});
        check_field("period_now", want.period_now, out_period_now);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_TOGGLE, 2);
    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_FASTER, 1);
    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_TOGGLE & PRESS_FASTER & PRESS_SLOWER & PRESS_SPARE, 1);
    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_SPARE, 1);
    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_FASTER & PRESS_SLOWER, 1);
    push_ticks(KEYS_IDLE, 1);
    push_ticks(PRESS_SLOWER, 1);
    push_ticks(KEYS_IDLE, 2);
    push_ticks(PRESS_SLOWER & PRESS_SPARE, 2);
    push_ticks(KEYS_IDLE, 3);
    queue_key_ticks(200);
    settle();

    run_phase(4'd1, 4'd15, 220);
    run_phase(4'd15, 4'd15, 220);
    run_phase(4'd0, 4'd3, 220);
    run_phase(4'd9, 4'd2, 220);
    run_phase(4'd1, 4'd1, 220);
    run_phase(4'd15, 4'd1, 220);
    run_phase(4'd2, 4'd12, 220);

    if (errors == 0 && expected_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
